// ===== rtl/pli_pkg.sv =====
// shared types and codes for the positional insert/delete list
// no dependencies; imported by pli_dec, pli_seq and positional_list_insert_delete
package pli_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int REQ_W   = 3;
    localparam int INDEX_W = 16;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 9;

    localparam logic [REQ_W-1:0] REQ_READ       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_INDEX  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_READ   = 2'd1,
        K_INSERT = 2'd2,
        K_DELETE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [STAT_W-1:0]  status;
    } t_dec;

endpackage

// ===== rtl/pli_dec.sv =====
// request decode: range and full checks, start position of the walk
// depends on pli_pkg
module pli_dec #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic [pli_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [pli_pkg::INDEX_W-1:0] i_index,
    input  logic [CW-1:0]                      i_count,
    output pli_pkg::t_dec                      o_dec,
    output logic [AW-1:0]                      o_pos
);
    import pli_pkg::*;

    logic               idx_neg;
    logic [INDEX_W-1:0] idx_u;
    logic [INDEX_W-1:0] cnt_u;
    logic               in_range;
    logic [INDEX_W-1:0] ins_pos;
    logic               is_full;

    assign idx_neg  = i_index[INDEX_W-1];
    assign idx_u    = INDEX_W'(i_index);
    assign cnt_u    = INDEX_W'(i_count);
    assign in_range = !idx_neg && (idx_u < cnt_u);
    assign is_full  = (i_count == CW'(CAPACITY));

    always_comb begin
        ins_pos      = '0;
        o_dec.kind   = K_NONE;
        o_dec.status = ST_RANGE;
        case (i_req_type)
            REQ_READ: begin
                ins_pos = idx_u;
                if (in_range) begin
                    o_dec.kind   = K_READ;
                    o_dec.status = ST_DONE;
                end
            end
            REQ_INS_INDEX, REQ_INS_HEAD, REQ_INS_TAIL: begin
                if (i_req_type == REQ_INS_TAIL) begin
                    ins_pos = cnt_u;
                end else if (i_req_type == REQ_INS_HEAD || idx_neg) begin
                    ins_pos = '0;
                end else begin
                    ins_pos = idx_u;
                end
                // range check comes before the full check
                if (ins_pos > cnt_u) begin
                    o_dec.status = ST_RANGE;
                end else if (is_full) begin
                    o_dec.status = ST_FULL;
                end else begin
                    o_dec.kind   = K_INSERT;
                    o_dec.status = ST_DONE;
                end
            end
            REQ_DELETE: begin
                ins_pos = idx_u;
                if (in_range) begin
                    o_dec.kind   = K_DELETE;
                    o_dec.status = ST_DONE;
                end
            end
            default: begin
                ins_pos = '0;
            end
        endcase
    end

    assign o_pos = ins_pos[AW-1:0];

endmodule

// ===== rtl/pli_seq.sv =====
// entry memory, count and the sequencer that walks entries one at a time
// depends on pli_pkg
module pli_seq #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  pli_pkg::t_dec                     i_dec,
    input  logic [AW-1:0]                     i_pos,
    input  logic [pli_pkg::DATA_W-1:0]        i_value,
    input  logic                              i_out_free,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [pli_pkg::STAT_W-1:0]        o_status,
    output logic [pli_pkg::DATA_W-1:0]        o_read_value,
    output logic [CW-1:0]                     o_count
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    logic [DATA_W-1:0] mem [CAPACITY];

    t_state            r_state,  n_state;
    t_kind             r_kind,   n_kind;
    logic [STAT_W-1:0] r_status, n_status;
    logic [AW-1:0]     r_pos,    n_pos;
    logic [AW-1:0]     r_ptr,    n_ptr;
    logic [DATA_W-1:0] r_val,    n_val;
    logic [CW-1:0]     r_count,  n_count;
    logic [DATA_W-1:0] r_rdata;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     last_addr;

    assign last_addr = AW'(r_count - CW'(1));

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_status = r_status;
        n_pos    = r_pos;
        n_ptr    = r_ptr;
        n_val    = r_val;
        n_count  = r_count;
        rd_en    = 1'b0;
        rd_addr  = r_ptr;
        wr_en    = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = r_rdata;
        o_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind   = i_dec.kind;
                    n_status = i_dec.status;
                    n_pos    = i_pos;
                    n_val    = i_value;
                    n_ptr    = (i_dec.kind == K_INSERT) ? AW'(r_count) : i_pos;
                    n_state  = (i_dec.kind == K_NONE) ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                case (r_kind)
                    K_READ: begin
                        rd_en   = 1'b1;
                        rd_addr = r_pos;
                        n_state = S_FIN;
                    end
                    K_INSERT: begin
                        if (r_ptr == r_pos) begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos;
                            wr_data = r_val;
                            n_count = r_count + CW'(1);
                            n_state = S_FIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_ptr - AW'(1);
                            n_state = S_WR;
                        end
                    end
                    K_DELETE: begin
                        if (r_ptr == last_addr) begin
                            n_count = r_count - CW'(1);
                            n_state = S_FIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_ptr + AW'(1);
                            n_state = S_WR;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rdata;
                n_ptr   = (r_kind == K_INSERT) ? r_ptr - AW'(1) : r_ptr + AW'(1);
                n_state = S_RD;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_ptr    <= n_ptr;
        r_val    <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_status     = r_status;
    assign o_read_value = (r_kind == K_READ) ? r_rdata : MISS_VALUE;
    assign o_count      = r_count;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// top level of the positional insert/delete list with request and result ports
// depends on pli_pkg, pli_dec and pli_seq
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_req_type, i_index, i_value
//  result    out        o_out_valid / i_out_stall o_status, o_read_value, o_length
//
// one request at a time; a refused request goes straight to the finish state,
// a read does one memory read, an insert at position p moves the entries from p
// to the end up one place and a delete at p moves those after p down one place:
// every moved entry costs one read and one write of the entry memory
// reset (synchronous, active low) clears the count and the sequencer; entries
// keep whatever they hold and are only read below the count
// a result waits in the output register while the next request is accepted;
// the sequencer holds its last step while that register is still occupied
module positional_list_insert_delete #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pli_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [pli_pkg::INDEX_W-1:0] i_index,
    input  logic signed [pli_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pli_pkg::STAT_W-1:0]         o_status,
    output logic signed [pli_pkg::DATA_W-1:0]  o_read_value,
    output logic [pli_pkg::LEN_W-1:0]          o_length
);
    import pli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // request decode against the current count
    t_dec              dec;
    logic [AW-1:0]     dec_pos;
    logic [CW-1:0]     count;

    // sequencer handshake and result
    logic              start;
    logic              busy;
    logic              done;
    logic              out_free;
    logic [STAT_W-1:0] seq_status;
    logic [DATA_W-1:0] seq_rdata;

    // output register
    logic              r_out_vld;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_rdata;
    logic [LEN_W-1:0]  r_length;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    // output register is free when empty or drained this cycle
    assign out_free   = !r_out_vld || !i_out_stall;

    pli_dec #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_dec (
        .i_req_type (i_req_type),
        .i_index    (i_index),
        .i_count    (count),
        .o_dec      (dec),
        .o_pos      (dec_pos)
    );

    pli_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_dec        (dec),
        .i_pos        (dec_pos),
        .i_value      (DATA_W'(i_value)),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_done       (done),
        .o_status     (seq_status),
        .o_read_value (seq_rdata),
        .o_count      (count)
    );

    // result valid: set on sequencer finish, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload, count already reflects this request
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status <= seq_status;
            r_rdata  <= seq_rdata;
            r_length <= LEN_W'(count);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_status;
    assign o_read_value = r_rdata;
    assign o_length     = r_length;

endmodule
